@@ hdl/fh64_pkg.sv @@
`default_nettype none

package fh64_pkg;

    localparam logic [63:0] MUL_M   = 64'h8803_55f2_1e6d_1965;
    localparam logic [63:0] MIX_K   = 64'h2127_599b_f432_5c37;
    localparam int          SHIFT_A = 23;
    localparam int          SHIFT_B = 47;

    // status of the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic logic [63:0] premix(input logic [63:0] x);
        return x ^ (x >> SHIFT_A);
    endfunction

    function automatic logic [63:0] postmix(input logic [63:0] x);
        return x ^ (x >> SHIFT_B);
    endfunction

    // keep only the low bytes that count says are valid, counts above eight keep all
    function automatic logic [63:0] mask_word(input logic [63:0] word,
                                              input logic [3:0]  count);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < count)
            begin
                res[i*8 +: 8] = word[i*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/fasthash64_engine_unit.sv @@
`default_nettype none

// fasthash64 engine: hashes a message streamed as little-endian 64-bit words.
// input channel: data_word, valid_bytes, message_length, last_word under
// in_valid / in_stall. message_length is read on the first request of a message;
// valid_bytes under eight marks a short word, zero absorbs nothing.
// output channel: digest under out_valid / out_stall, one request per last word.
// seed is written through cfg_we / cfg_wdata; the user must write it only while the
// engine is idle, the engine itself does not enforce this. all 64-bit products run
// on one 32x32 multiplier. a word with valid bytes takes two products; the first
// word of a message adds one product for the start value, the last word adds one
// product for the final mix and then loads the output register.
// in_stall is high while a request is being worked on.
// the output register holds the digest while out_stall is high; the engine
// takes the next request meanwhile and waits only if a second digest is ready.
// reset clears seed, the message state and out_valid; no clearing pass.
module fasthash64_engine_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic [31:0] message_length,
    input  wire logic        last_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INIT = 6'b000010,
        ST_MIXW = 6'b000100,
        ST_ACCM = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [63:0]         seed_reg;
    logic [63:0]         acc_reg;
    logic [63:0]         acc_next;
    logic                mid_reg;
    logic                mid_next;
    logic [63:0]         wmix_reg;
    logic [63:0]         wmix_next;
    logic                nz_reg;
    logic                nz_next;
    logic                last_reg;
    logic                last_next;
    logic [63:0]         res_reg;
    logic [63:0]         res_next;
    logic [63:0]         digest_reg;
    logic [63:0]         digest_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                accept;
    logic                out_free;
    logic                mul_start;
    logic [63:0]         mul_a;
    logic [63:0]         mul_b;
    logic [63:0]         mul_prod;
    logic [63:0]         init_acc;
    fh64_pkg::mul_stat_t mul_stat;

    fh64_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign init_acc  = seed_reg ^ mul_prod;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        mid_next       = mid_reg;
        wmix_next      = wmix_reg;
        nz_next        = nz_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wmix_next = fh64_pkg::premix(fh64_pkg::mask_word(data_word, valid_bytes));
                    nz_next   = (valid_bytes != 4'd0);
                    last_next = last_word;
                    if (!mid_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = 64'(message_length);
                        mul_b      = fh64_pkg::MUL_M;
                        state_next = ST_INIT;
                    end
                    else if (valid_bytes != 4'd0)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = fh64_pkg::premix(
                                         fh64_pkg::mask_word(data_word, valid_bytes));
                        mul_b      = fh64_pkg::MIX_K;
                        state_next = ST_MIXW;
                    end
                    else if (last_word)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = fh64_pkg::premix(acc_reg);
                        mul_b      = fh64_pkg::MIX_K;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_INIT:
            begin
                if (mul_stat.done)
                begin
                    acc_next = init_acc;
                    if (nz_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = wmix_reg;
                        mul_b      = fh64_pkg::MIX_K;
                        state_next = ST_MIXW;
                    end
                    else if (last_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = fh64_pkg::premix(init_acc);
                        mul_b      = fh64_pkg::MIX_K;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        mid_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MIXW:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_reg ^ fh64_pkg::postmix(mul_prod);
                    mul_b      = fh64_pkg::MUL_M;
                    state_next = ST_ACCM;
                end
            end
            ST_ACCM:
            begin
                if (mul_stat.done)
                begin
                    acc_next = mul_prod;
                    if (last_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = fh64_pkg::premix(mul_prod);
                        mul_b      = fh64_pkg::MIX_K;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        mid_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN:
            begin
                if (mul_stat.done)
                begin
                    res_next   = fh64_pkg::postmix(mul_prod);
                    mid_next   = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    digest_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        wmix_reg   <= wmix_next;
        nz_reg     <= nz_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        digest_reg <= digest_next;
    end

    // multiplier finishes only while a product is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg != ST_IDLE && state_reg != ST_EMIT))
        else $error("multiplier done outside a product step");

    // no request is taken while the multiplier still runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mul_stat.busy)
        else $error("multiplier busy while idle");

    // a new digest appears only from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(state_reg == ST_EMIT))
        else $error("digest without emit step");

    // a finished message always leaves the engine waiting for a first word
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !mid_reg)
        else $error("message state not cleared at emit");

endmodule

`default_nettype wire

@@ hdl/fh64_mul.sv @@
`default_nettype none

// low 64 bits of a 64x64 product from three 32x32 partial products
module fh64_mul
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [63:0]       op_a,
    input  wire logic [63:0]       op_b,
    output fh64_pkg::mul_stat_t    stat,
    output logic [63:0]            product
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg;
    logic [63:0] sum_next;
    logic [1:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] mul_p;

    always_comb
    begin
        case (cnt_reg)
            2'd1:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            2'd2:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
        endcase
    end

    assign mul_p = 64'(op_x) * 64'(op_y);

    // cross terms only reach the upper half
    always_comb
    begin
        case (cnt_reg)
            2'd1:    sum_next = prod_reg;
            2'd2:    sum_next = sum_reg + {prod_reg[31:0], 32'd0};
            default: sum_next = sum_reg;
        endcase
    end

    assign product   = sum_reg + {prod_reg[31:0], 32'd0};
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 2'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        prod_reg <= mul_p;
        sum_reg  <= sum_next;
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;

    localparam int PHASE_REQUESTS = 140;
    localparam int NUM_PHASES     = 5;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic [31:0] len;
        logic        last;
        logic        known;
        logic [63:0] digest;
    } stim_row_t;

    localparam int NUM_ROWS = 21;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] data_word = '0;
    logic [3:0]  valid_bytes = '0;
    logic [31:0] message_length = '0;
    logic        last_word = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;

    // predictor state
    logic [63:0] seed_reg = '0;
    logic [63:0] hash_acc = '0;
    bit          in_message = 1'b0;

    logic [63:0] pending_digests[$];
    int          n_requests = 0;
    int          n_messages = 0;
    int          n_digests = 0;
    int          n_errors = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    // directed requests; the digest is typed in only for the empty message at seed zero
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  32'd0,          1'b1, 1'b1, 64'h0},
        '{64'h0000_0000_0000_0000, 4'd8,  32'd8,          1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'hFFFF_FFFF,  1'b1, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd8,          1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd9,  32'd8,          1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd8,  32'd9,          1'b0, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FF5A, 4'd1,  32'd9,          1'b1, 1'b0, 64'h0},
        '{64'h0F1E_2D3C_4B5A_6978, 4'd8,  32'd23,         1'b0, 1'b0, 64'h0},
        '{64'h8796_A5B4_C3D2_E1F0, 4'd8,  32'd23,         1'b0, 1'b0, 64'h0},
        '{64'hAB00_1122_3344_5566, 4'd7,  32'd23,         1'b1, 1'b0, 64'h0},
        '{64'hDEAD_BEEF_CAFE_F00D, 4'd3,  32'd11,         1'b0, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0001, 4'd8,  32'hFFFF_FFFF,  1'b1, 1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd0,  32'd16,         1'b0, 1'b0, 64'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  32'd16,         1'b0, 1'b0, 64'h0},
        '{64'h7FFF_FFFF_FFFF_FFFF, 4'd0,  32'd16,         1'b1, 1'b0, 64'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd8,  32'd100,        1'b1, 1'b0, 64'h0},
        '{64'h1234_5678_9ABC_DEF0, 4'd4,  32'd4,          1'b1, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0000, 4'd0,  32'h8000_0000,  1'b1, 1'b0, 64'h0},
        '{64'hC3C3_C3C3_C3C3_C3C3, 4'd2,  32'd2,          1'b1, 1'b0, 64'h0},
        '{64'h3C3C_3C3C_3C3C_3C3C, 4'd5,  32'd5,          1'b1, 1'b0, 64'h0},
        '{64'h0102_0408_1020_4080, 4'd6,  32'd6,          1'b1, 1'b0, 64'h0}
    };

    fasthash64_engine_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .message_length (message_length),
        .last_word      (last_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest         (digest),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] avalanche(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v >> 23);
        x = x * fh64_pkg::MIX_K;
        return x ^ (x >> 47);
    endfunction

    // advances the predicted hash state by one request, returns 1 when a digest is due
    function automatic bit hash_request(input logic [63:0] w, input logic [3:0] nbytes,
                                        input logic [31:0] len, input logic last,
                                        output logic [63:0] dg);
        int          n;
        logic [63:0] x;
        n = (nbytes > 4'd8) ? 8 : int'(nbytes);
        if (!in_message)
        begin
            hash_acc = seed_reg ^ (64'(len) * fh64_pkg::MUL_M);
        end
        if (n != 0)
        begin
            x = (n < 8) ? (w & ((64'd1 << (8 * n)) - 64'd1)) : w;
            hash_acc = (hash_acc ^ avalanche(x)) * fh64_pkg::MUL_M;
        end
        dg = avalanche(hash_acc);
        in_message = !last;
        return last;
    endfunction

    task automatic push_request(input logic [63:0] w, input logic [3:0] nbytes,
                                input logic [31:0] len, input logic last,
                                input logic known, input logic [63:0] known_digest);
        logic [63:0] dg;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_word      <= w;
        valid_bytes    <= nbytes;
        message_length <= len;
        last_word      <= last;
        do
            @(posedge clk);
        while (in_stall);
        n_requests++;
        if (hash_request(w, nbytes, len, last, dg))
        begin
            n_messages++;
            pending_digests.push_back(known ? known_digest : dg);
        end
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 64'h0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly well-formed messages, some with odd byte counts and lengths
    task automatic send_message();
        int          nbytes;
        int          nwords;
        int          pick;
        logic [3:0]  nb;
        logic [31:0] len;
        if ($urandom_range(0, 9) < 8)
        begin
            pick   = $urandom_range(0, 19);
            nbytes = (pick == 0) ? 0 : (pick < 17) ? $urandom_range(1, 24)
                                                   : $urandom_range(25, 80);
            len    = ($urandom_range(0, 9) == 0) ? $urandom : 32'(nbytes);
            nwords = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
            for (int i = 0; i < nwords; i++)
            begin
                if (nbytes == 0)
                    nb = 4'd0;
                else if (i == nwords - 1 && nbytes % 8 != 0)
                    nb = 4'(nbytes % 8);
                else
                    nb = 4'd8;
                push_request(random_word(), nb, (i == 0) ? len : $urandom, i == nwords - 1,
                             1'b0, 64'h0);
            end
        end
        else
        begin
            nwords = $urandom_range(1, 5);
            for (int i = 0; i < nwords; i++)
            begin
                push_request(random_word(), 4'($urandom_range(0, 15)), $urandom,
                             i == nwords - 1, 1'b0, 64'h0);
            end
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        seed_reg = value;
        cfg_we   <= 1'b0;
    endtask

    // receiver stall in random bursts
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_digests++;
            if (pending_digests.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none got %h", $time, digest);
                n_errors++;
            end
            else if (digest !== pending_digests[0])
            begin
                $display("%0t: digest mismatch, expected %h got %h",
                         $time, pending_digests[0], digest);
                n_errors++;
                void'(pending_digests.pop_front());
            end
            else
            begin
                void'(pending_digests.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] next_seed;
        int          phase_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset seed is zero, so the directed part runs unconfigured
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            push_request(directed_rows[r].word, directed_rows[r].nbytes,
                         directed_rows[r].len, directed_rows[r].last,
                         directed_rows[r].known, directed_rows[r].digest);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_and_settle();
            case (p)
                0:       next_seed = 64'hFFFF_FFFF_FFFF_FFFF;
                1:       next_seed = 64'h0;
                3:       next_seed = 64'h8000_0000_0000_0001;
                default: next_seed = {$urandom, $urandom};
            endcase
            write_seed(next_seed);
            // last phase runs at full rate on both sides
            quiet = (p == NUM_PHASES - 1);
            phase_start = n_requests;
            while (n_requests - phase_start < PHASE_REQUESTS) send_message();
        end
        drain_and_settle();

        $display("%0d requests in %0d messages, %0d digests checked over %0d seed settings",
                 n_requests, n_messages, n_digests, NUM_PHASES + 1);
        $display("covered empty messages, short and oversized byte counts, odd lengths");
        if (n_errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
